@@ hw/rtl/pit_pkg.sv @@
// Shared types and constants for the pointer intern table.
// Request and response payload structs, status codes and state encodings.
// No dependencies.
`default_nettype none

package pit_pkg;

	localparam int unsigned KEY_W         = 64;
	localparam int unsigned ID_W          = 10;
	localparam int unsigned MAP_SLOTS_DEF = 2048;
	localparam int unsigned ID_SLOTS_DEF  = 1024;

	typedef enum logic [1:0] {
		ST_HIT     = 2'd0,
		ST_ADDED   = 2'd1,
		ST_INVALID = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic {
		FN_INTERN  = 1'b0,
		FN_RESOLVE = 1'b1
	} func_t;

	typedef struct packed {
		func_t             func;
		logic [KEY_W-1:0]  key;
		logic [ID_W-1:0]   query_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]   result_id;
		logic [KEY_W-1:0]  result_key;
		status_t           status;
	} rsp_t;

	typedef enum logic [1:0] {
		PR_HIT   = 2'd0,
		PR_ADDED = 2'd1,
		PR_FULL  = 2'd2
	} probe_kind_t;

	typedef struct packed {
		logic start;
		logic can_add;
	} probe_ctl_t;

	typedef struct packed {
		logic        ready;
		logic        done;
		probe_kind_t kind;
	} probe_sts_t;

	typedef enum logic [1:0] {
		PS_CLEAR = 2'd0,
		PS_IDLE  = 2'd1,
		PS_CHECK = 2'd2
	} probe_state_t;

	typedef enum logic [1:0] {
		TS_IDLE   = 2'd0,
		TS_RES_RD = 2'd1,
		TS_PROBE  = 2'd2,
		TS_EMIT   = 2'd3
	} top_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/pointer_intern_table.sv @@
// Top level of the pointer intern table: request decode, id-to-key store,
// id counter and output register. Depends on pit_pkg and pit_probe.
//
// One request is worked on at a time. A resolve of a valid id reads the
// id-to-key store into a register, registers its response and then loads it
// into the output register; the next request can be accepted after that load.
// A null key or an invalid id has its response registered, then loaded into
// the output register, after which the next request can follow. An intern
// request walks the slot map one slot per cycle, since the slot memory has a
// single read port, and its response is loaded once the walk ends. After reset
// the slot map runs a clearing pass over every slot, during which in_ready
// stays low. A finished response waits in the output register without
// blocking the next request from being accepted; a second finished response
// waits until the first has been taken.
`default_nettype none

module pointer_intern_table #(
	parameter int unsigned MAP_SLOTS = pit_pkg::MAP_SLOTS_DEF,
	parameter int unsigned ID_SLOTS  = pit_pkg::ID_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pit_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output pit_pkg::rsp_t out_data
);
	import pit_pkg::*;

	localparam int unsigned ID_AW = $clog2(ID_SLOTS);
	localparam int unsigned CMP_W = ((ID_AW > ID_W) ? ID_AW : ID_W) + 1;

	top_state_t          state_q, state_d;
	logic [ID_AW-1:0]    count_q;
	logic [KEY_W-1:0]    key_q;
	rsp_t                res_q, res_d;
	rsp_t                out_q;
	logic                out_valid_q;

	logic [KEY_W-1:0]    ks_mem [ID_SLOTS];
	logic [KEY_W-1:0]    ks_rd_q;
	logic                ks_rd_en, ks_wr_en;

	logic                in_acc;
	logic [CMP_W-1:0]    qid_w;
	logic                qid_ok;
	logic [ID_AW-1:0]    new_id;
	logic                can_add;
	logic                cnt_inc;
	logic                load_out;

	probe_ctl_t          pctl;
	probe_sts_t          psts;
	logic [ID_AW-1:0]    hit_id;

	pit_probe #(
		.MAP_SLOTS (MAP_SLOTS),
		.ID_SLOTS  (ID_SLOTS)
	) u_probe (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pctl),
		.key    (in_data.key),
		.new_id (new_id),
		.sts    (psts),
		.hit_id (hit_id)
	);

	assign in_ready  = (state_q == TS_IDLE) && psts.ready;
	assign in_acc    = in_valid && in_ready;
	assign qid_w     = CMP_W'(in_data.query_id);
	assign qid_ok    = (qid_w != '0) && (qid_w <= CMP_W'(count_q))
		&& (qid_w < CMP_W'(ID_SLOTS));
	assign new_id    = count_q + 1'b1;
	assign can_add   = ((ID_AW + 1)'(count_q) + 1'b1) < (ID_AW + 1)'(ID_SLOTS);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		pctl     = '0;
		ks_rd_en = 1'b0;
		ks_wr_en = 1'b0;
		cnt_inc  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			TS_IDLE: begin
				if (in_acc) begin
					case (in_data.func)
						FN_RESOLVE: begin
							if (qid_ok) begin
								ks_rd_en        = 1'b1;
								res_d.result_id = in_data.query_id;
								state_d         = TS_RES_RD;
							end else begin
								res_d   = '{result_id: '0, result_key: '0, status: ST_INVALID};
								state_d = TS_EMIT;
							end
						end
						default: begin
							if (in_data.key == '0) begin
								res_d   = '{result_id: '0, result_key: '0, status: ST_INVALID};
								state_d = TS_EMIT;
							end else begin
								pctl.start   = 1'b1;
								pctl.can_add = can_add;
								state_d      = TS_PROBE;
							end
						end
					endcase
				end
			end
			TS_RES_RD: begin
				res_d.result_key = ks_rd_q;
				res_d.status     = ST_HIT;
				state_d          = TS_EMIT;
			end
			TS_PROBE: begin
				if (psts.done) begin
					state_d = TS_EMIT;
					case (psts.kind)
						PR_HIT: begin
							res_d = '{result_id: ID_W'(hit_id), result_key: key_q,
								status: ST_HIT};
						end
						PR_ADDED: begin
							res_d    = '{result_id: ID_W'(new_id), result_key: key_q,
								status: ST_ADDED};
							ks_wr_en = 1'b1;
							cnt_inc  = 1'b1;
						end
						default: begin
							res_d = '{result_id: '0, result_key: '0, status: ST_FULL};
						end
					endcase
				end
			end
			TS_EMIT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = TS_IDLE;
				end
			end
			default: begin
				state_d = TS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TS_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				count_q <= new_id;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (in_acc) begin
			key_q <= in_data.key;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ks_wr_en) begin
			ks_mem[new_id] <= key_q;
		end
		if (ks_rd_en) begin
			ks_rd_q <= ks_mem[qid_w[ID_AW-1:0]];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/pit_probe.sv @@
// Slot map of the pointer intern table: slot memory, clearing pass after
// reset and the linear probe walk, one slot per cycle. Depends on pit_pkg.
`default_nettype none

module pit_probe #(
	parameter int unsigned MAP_SLOTS = pit_pkg::MAP_SLOTS_DEF,
	parameter int unsigned ID_SLOTS  = pit_pkg::ID_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pit_pkg::probe_ctl_t           ctl,
	input  logic [pit_pkg::KEY_W-1:0]     key,
	input  logic [$clog2(ID_SLOTS)-1:0]   new_id,
	output pit_pkg::probe_sts_t           sts,
	output logic [$clog2(ID_SLOTS)-1:0]   hit_id
);
	import pit_pkg::*;

	localparam int unsigned MAP_AW = $clog2(MAP_SLOTS);
	localparam int unsigned ID_AW  = $clog2(ID_SLOTS);
	localparam int unsigned WORD_W = 1 + ID_AW + KEY_W;
	localparam int unsigned FOLD_N = (KEY_W + MAP_AW - 1) / MAP_AW;
	localparam logic [MAP_AW-1:0] LAST_IDX = MAP_AW'(MAP_SLOTS - 1);

	probe_state_t        state_q, state_d;
	logic [MAP_AW-1:0]   idx_q, idx_d;
	logic [MAP_AW-1:0]   n_q, n_d;
	logic [MAP_AW-1:0]   clr_q;
	logic [KEY_W-1:0]    key_q;
	logic                can_add_q;
	logic [ID_AW-1:0]    new_id_q;

	logic [WORD_W-1:0]   mem [MAP_SLOTS];
	logic [WORD_W-1:0]   rd_word_q;
	logic                rd_en, wr_en;
	logic [MAP_AW-1:0]   rd_addr, wr_addr;
	logic [WORD_W-1:0]   wr_word;

	logic [MAP_AW-1:0]   fold;
	logic [MAP_AW-1:0]   start_idx;
	logic [MAP_AW-1:0]   next_idx;
	logic                slot_used;
	logic [KEY_W-1:0]    slot_key;

	always_comb begin
		fold = '0;
		for (int c = 0; c < FOLD_N; c++) begin
			for (int j = 0; j < MAP_AW; j++) begin
				if (c * MAP_AW + j < KEY_W) begin
					fold[j] = fold[j] ^ key[c * MAP_AW + j];
				end
			end
		end
		if ({1'b0, fold} >= (MAP_AW + 1)'(MAP_SLOTS)) begin
			start_idx = MAP_AW'({1'b0, fold} - (MAP_AW + 1)'(MAP_SLOTS));
		end else begin
			start_idx = fold;
		end
	end

	assign slot_used = rd_word_q[WORD_W-1];
	assign hit_id    = rd_word_q[KEY_W +: ID_AW];
	assign slot_key  = rd_word_q[KEY_W-1:0];
	assign next_idx  = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		n_d       = n_q;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_word   = {1'b1, new_id_q, key_q};
		sts       = '{ready: 1'b0, done: 1'b0, kind: PR_FULL};
		case (state_q)
			PS_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_word = '0;
				if (clr_q == LAST_IDX) begin
					state_d = PS_IDLE;
				end
			end
			PS_IDLE: begin
				sts.ready = 1'b1;
				if (ctl.start) begin
					rd_en   = 1'b1;
					rd_addr = start_idx;
					idx_d   = start_idx;
					n_d     = '0;
					state_d = PS_CHECK;
				end
			end
			PS_CHECK: begin
				if (!slot_used) begin
					sts.done = 1'b1;
					state_d  = PS_IDLE;
					if (can_add_q) begin
						wr_en    = 1'b1;
						sts.kind = PR_ADDED;
					end
				end else if (slot_key == key_q) begin
					sts.done = 1'b1;
					sts.kind = PR_HIT;
					state_d  = PS_IDLE;
				end else if (n_q == LAST_IDX) begin
					sts.done = 1'b1;
					state_d  = PS_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = next_idx;
					idx_d   = next_idx;
					n_d     = n_q + 1'b1;
				end
			end
			default: begin
				state_d = PS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == PS_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		n_q   <= n_d;
		if (state_q == PS_IDLE && ctl.start) begin
			key_q     <= key;
			can_add_q <= ctl.can_add;
			new_id_q  <= new_id;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Testbench for pointer_intern_table: random and directed intern and resolve
// requests, checked against a behavioral model of the interning table.
// Depends on pit_pkg and the pointer_intern_table RTL.
`timescale 1ns / 1ps

module tb;
	import pit_pkg::*;

	localparam int ID_SLOTS    = ID_SLOTS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LAST_ID     = ID_SLOTS - 1;

	typedef struct {
		req_t req;
		bit   hold;
	} pending_req_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	req_t in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	pending_req_t req_queue[$];
	rsp_t answers_due[$];

	logic [ID_W-1:0]  id_of_key[logic [KEY_W-1:0]];
	logic [KEY_W-1:0] key_of_id[ID_SLOTS];
	int unsigned      ids_assigned = 0;

	logic [KEY_W-1:0] queued_keys[$];
	bit               queued_seen[logic [KEY_W-1:0]];

	int          burst_left  = 0;
	int          gap_left    = 0;
	logic [15:0] ready_bits  = 16'hFFFF;
	int          ready_age   = 0;
	int          fail_count  = 0;
	int          cycle_count = 0;

	pointer_intern_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	function automatic rsp_t intern_answer(input req_t r);
		rsp_t rsp;
		rsp = '{result_id: '0, result_key: '0, status: ST_INVALID};
		if (r.func == FN_RESOLVE) begin
			if (r.query_id != 0 && r.query_id <= ids_assigned) begin
				rsp.result_id  = r.query_id;
				rsp.result_key = key_of_id[r.query_id];
				rsp.status     = ST_HIT;
			end
		end else if (r.key != '0) begin
			if (id_of_key.exists(r.key)) begin
				rsp.result_id  = id_of_key[r.key];
				rsp.result_key = r.key;
				rsp.status     = ST_HIT;
			end else if (ids_assigned + 1 >= ID_SLOTS) begin
				rsp.status = ST_FULL;
			end else begin
				ids_assigned++;
				id_of_key[r.key]        = ids_assigned[ID_W-1:0];
				key_of_id[ids_assigned] = r.key;
				rsp.result_id           = ids_assigned[ID_W-1:0];
				rsp.result_key          = r.key;
				rsp.status              = ST_ADDED;
			end
		end
		return rsp;
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	task automatic queue_req(input func_t f, input logic [KEY_W-1:0] k,
			input logic [ID_W-1:0] q, input bit hold = 1'b0);
		pending_req_t p;
		p.req.func     = f;
		p.req.key      = k;
		p.req.query_id = q;
		p.hold         = hold;
		req_queue.push_back(p);
	endtask

	task automatic queue_intern(input logic [KEY_W-1:0] k, input bit hold = 1'b0);
		if (k != '0 && !queued_seen.exists(k) && queued_keys.size() < LAST_ID) begin
			queued_seen[k] = 1'b1;
			queued_keys.push_back(k);
		end
		queue_req(FN_INTERN, k, ID_W'($urandom_range(0, LAST_ID)), hold);
	endtask

	function automatic logic [KEY_W-1:0] known_key();
		return queued_keys[$urandom_range(0, queued_keys.size() - 1)];
	endfunction

	task automatic queue_resolve_valid(input bit hold = 1'b0);
		queue_req(FN_RESOLVE, rand_key(), ID_W'($urandom_range(1, queued_keys.size())), hold);
	endtask

	task automatic queue_resolve_invalid();
		if (queued_keys.size() < LAST_ID && $urandom_range(0, 2) != 0) begin
			queue_req(FN_RESOLVE, rand_key(),
				ID_W'($urandom_range(queued_keys.size() + 1, LAST_ID)));
		end else begin
			queue_req(FN_RESOLVE, rand_key(), '0);
		end
	endtask

	task automatic show_mismatch(input string what, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
		fail_count++;
	endtask

	always @(posedge clk) begin
		pending_req_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				answers_due.push_back(intern_answer(in_data));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (req_queue.size() != 0 &&
						!(req_queue[0].hold && answers_due.size() != 0)) begin
					nxt = req_queue.pop_front();
					in_valid <= 1'b1;
					in_data  <= nxt.req;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: response with no request pending: id %h key %h status %h",
						$time, out_data.result_id, out_data.result_key, out_data.status);
					fail_count++;
				end else begin
					rsp_t want;
					want = answers_due.pop_front();
					if (out_data.result_id !== want.result_id) begin
						show_mismatch("result_id", KEY_W'(want.result_id),
							KEY_W'(out_data.result_id));
					end
					if (out_data.result_key !== want.result_key) begin
						show_mismatch("result_key", want.result_key, out_data.result_key);
					end
					if (out_data.status !== want.status) begin
						show_mismatch("status", KEY_W'(want.status), KEY_W'(out_data.status));
					end
				end
			end
			if (ready_age == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						ready_bits = 16'hFFFF;
					end
					1: begin
						ready_bits = 16'($urandom());
					end
					default: begin
						ready_bits = 16'($urandom() & $urandom());
					end
				endcase
				ready_bits[0] = 1'b1;
				ready_age     = $urandom_range(20, 120);
			end else begin
				ready_age--;
			end
			out_ready  <= ready_bits[0];
			ready_bits = {ready_bits[0], ready_bits[15:1]};
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		int               pick;
		logic [KEY_W-1:0] base;

		queue_req(FN_RESOLVE, '0, '0);
		queue_req(FN_RESOLVE, '1, 10'd1);
		queue_req(FN_RESOLVE, '0, LAST_ID[ID_W-1:0]);
		queue_req(FN_INTERN, '0, '1);
		queue_intern('1);
		queue_intern(64'd1);
		queue_intern(64'h8000_0000_0000_0000);
		queue_intern('1);
		queue_req(FN_RESOLVE, '0, 10'd1);
		queue_req(FN_RESOLVE, '1, 10'd3);
		queue_req(FN_RESOLVE, '0, 10'd4);
		queue_intern(64'h5555_5555_5555_5555);
		queue_intern(64'hAAAA_AAAA_AAAA_AAAA);
		for (int i = 2; i < 6; i++) begin
			queue_intern(KEY_W'(i));
		end
		queue_intern(64'd1);
		queue_req(FN_RESOLVE, '1, 10'd9);
		queue_req(FN_RESOLVE, '1, 10'd10);
		queue_req(FN_INTERN, '0, ID_W'($urandom_range(0, LAST_ID)));
		queue_resolve_valid(1'b1);

		for (int i = 0; i < 150; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				queue_intern(rand_key());
			end else if (pick < 60) begin
				queue_intern(known_key());
			end else if (pick < 78) begin
				queue_resolve_valid();
			end else if (pick < 88) begin
				queue_resolve_invalid();
			end else if (pick < 93) begin
				queue_req(FN_INTERN, '0, ID_W'($urandom_range(0, LAST_ID)));
			end else begin
				base = known_key();
				queue_intern($urandom_range(0, 1) ? base + 1 : base ^ (64'd1 << $urandom_range(0, 63)));
			end
		end

		queue_intern(rand_key(), 1'b1);
		while (queued_keys.size() < LAST_ID) begin
			pick = $urandom_range(0, 99);
			if (pick < 90) begin
				queue_intern(rand_key(), $urandom_range(0, 99) == 0);
			end else if (pick < 94) begin
				queue_intern(known_key());
			end else if (pick < 97) begin
				queue_resolve_valid();
			end else begin
				queue_req(FN_RESOLVE, rand_key(), ID_W'($urandom_range(0, LAST_ID)));
			end
		end

		queue_req(FN_RESOLVE, '0, LAST_ID[ID_W-1:0], 1'b1);
		queue_req(FN_INTERN, rand_key(), '0);
		queue_req(FN_INTERN, '0, '0);
		queue_intern(queued_keys[LAST_ID - 1]);
		for (int i = 0; i < 80; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				queue_req(FN_INTERN, rand_key(), ID_W'($urandom_range(0, LAST_ID)));
			end else if (pick < 60) begin
				queue_intern(known_key());
			end else if (pick < 85) begin
				queue_resolve_valid();
			end else begin
				queue_resolve_invalid();
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (req_queue.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (answers_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
